// File: src/jhl_pkg.sv
// Package for the jump history list: widths, command and status codes, types.
// No dependencies.
package jhl_pkg;
  localparam int unsigned ListDepth = 64;
  localparam int unsigned IdxW = $clog2(ListDepth);
  localparam int unsigned CntW = $clog2(ListDepth + 1);
  localparam int unsigned LineW = 31;
  localparam int unsigned ColW = 16;
  localparam int unsigned FileW = 16;
  localparam int unsigned EntW = LineW + ColW + FileW;

  typedef enum logic [1:0] {
    CMD_RECORD = 2'd0,
    CMD_MOVE   = 2'd1,
    CMD_CHECK  = 2'd2,
    CMD_ADJUST = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NONE  = 2'd1,
    ST_OTHER = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_WR,
    S_APPEND,
    S_TGT,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [LineW-1:0] line;
    logic [ColW-1:0]  col;
    logic [FileW-1:0] file;
  } entry_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [LineW-1:0] cursor_line;
    logic [ColW-1:0]  cursor_col;
    logic [FileW-1:0] file_num;
    logic signed [7:0] step_count;
    logic [LineW-1:0] first_line;
    logic [LineW-1:0] last_line;
    logic signed [31:0] shift_amount;
    logic             delete_range;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [LineW-1:0] target_line;
    logic [ColW-1:0]  target_col;
    logic [FileW-1:0] target_file;
    logic [LineW-1:0] context_line;
    logic [ColW-1:0]  context_col;
    logic [6:0]       list_length;
    logic [6:0]       list_position;
  } rsp_t;

  // Shift or zero one line that lies in the inclusive range lo..hi.
  function automatic logic [LineW-1:0] adjust_line(logic [LineW-1:0] line,
      logic [LineW-1:0] lo, logic [LineW-1:0] hi, logic signed [31:0] sh,
      logic del);
    logic signed [33:0] v;
    logic [LineW-1:0] r;
    v = $signed({3'b000, line}) + 34'(sh);
    r = line;
    if (line >= lo && line <= hi) begin
      if (del) r = '0;
      else if (v < 0) r = '0;
      else if (v > 34'sh7FFFFFFF) r = {LineW{1'b1}};
      else r = v[LineW-1:0];
    end
    return r;
  endfunction
endpackage

// File: src/jhl_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on jhl_pkg.
interface jhl_req_if;
  logic valid;
  logic ready;
  jhl_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface jhl_rsp_if;
  logic valid;
  logic ready;
  jhl_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/jhl_ram.sv
// Generic simple dual-port synchronous RAM (one write, one read port) with registered read.
// No dependencies.
module jhl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: src/jump_history_list_core.sv
// Top level of the jump history list: sequencer around one entry RAM.
// Depends on jhl_pkg, jhl_if, jhl_ram.
//
//  channel | dir | transaction
//  req     | in  | one command with cursor, step and adjust range
//  rsp     | out | status, selected entry, context mark, length, cursor
//
// Record and adjust walk the list entry by entry, a read state and then a
// compact or rewrite state per entry. A record into a full list with no
// duplicate walks again to drop the oldest entry. A move that starts past the
// last entry records the cursor first. Reset clears length, cursor and context
// marks, not the RAM. A stalled response holds the core.
module jump_history_list_core (
  input  logic clk_i,
  input  logic rst_ni,
  jhl_req_if.sink   req,
  jhl_rsp_if.source rsp
);
  import jhl_pkg::*;

  state_e state_q, state_d;
  req_t   r_q;
  logic [CntW-1:0] len_q, len_d, pos_q, pos_d, idx_q, idx_d, kept_q, kept_d;
  logic [LineW-1:0] ctx_line_q, ctx_line_d, pctx_line_q, pctx_line_d;
  logic [ColW-1:0]  ctx_col_q, ctx_col_d, pctx_col_q, pctx_col_d;
  logic       mv_q, mv_d, drop_q, drop_d;
  logic [1:0] st_q, st_d;
  entry_t     tgt_q, tgt_d;

  logic       we;
  logic [IdxW-1:0] waddr, raddr;
  entry_t     wdata, rdata;

  jhl_ram #(.Width(EntW), .Depth(ListDepth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic accept;
  assign accept = req.valid && req.ready;
  assign req.ready = (state_q == S_IDLE);

  logic signed [9:0] step_idx;
  assign step_idx = $signed({3'b000, pos_q}) + 10'(r_q.step_count);

  // Step target after a record that precedes a move: cursor on the last entry.
  logic signed [9:0] app_idx;
  assign app_idx = $signed({3'b000, kept_q}) + 10'(r_q.step_count);

  logic mv_bad, app_bad, drop_start;
  assign mv_bad = (len_q == '0) || (step_idx < 0) ||
                  (step_idx >= $signed({3'b000, len_q}));
  assign app_bad = (app_idx < 0) || (app_idx > $signed({3'b000, kept_q}));
  // A full walk that kept every entry must drop the oldest: walk again from 1.
  assign drop_start = (r_q.cmd != CMD_ADJUST) && (kept_q == CntW'(ListDepth)) &&
                      !drop_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) begin
        case (cmd_e'(req.data.cmd))
          CMD_CHECK: state_d = S_OUT;
          CMD_MOVE:  state_d = S_TGT;
          default:   state_d = S_RD;
        endcase
      end
      S_RD: begin
        if (idx_q < len_q) state_d = S_WR;
        else if (drop_start) state_d = S_RD;
        else state_d = S_APPEND;
      end
      S_WR:     state_d = S_RD;
      S_APPEND: state_d = (mv_q && !app_bad) ? S_TGT : S_OUT;
      S_TGT: begin
        if (mv_q || mv_bad) state_d = S_OUT;
        else if (pos_q >= len_q) state_d = S_RD;
        else state_d = S_TGT;
      end
      S_OUT:    if (rsp.ready) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    len_d = len_q; pos_d = pos_q; idx_d = idx_q; kept_d = kept_q;
    ctx_line_d = ctx_line_q; ctx_col_d = ctx_col_q;
    pctx_line_d = pctx_line_q; pctx_col_d = pctx_col_q;
    mv_d = mv_q; drop_d = drop_q; st_d = st_q; tgt_d = tgt_q;
    we = 1'b0; waddr = kept_q[IdxW-1:0]; wdata = rdata;
    raddr = idx_q[IdxW-1:0];
    case (state_q)
      S_IDLE: begin
        idx_d = '0; kept_d = '0; mv_d = 1'b0; drop_d = 1'b0;
        st_d = ST_OK; tgt_d = '0;
        if (accept) begin
          raddr = '0;
          case (cmd_e'(req.data.cmd))
            CMD_RECORD: begin
              pctx_line_d = ctx_line_q; pctx_col_d = ctx_col_q;
              ctx_line_d = req.data.cursor_line; ctx_col_d = req.data.cursor_col;
            end
            CMD_CHECK: begin
              if (pctx_line_q != '0 &&
                  (ctx_line_q == req.data.cursor_line || ctx_line_q == '0)) begin
                ctx_line_d = pctx_line_q; ctx_col_d = pctx_col_q;
                pctx_line_d = '0;
              end
            end
            CMD_ADJUST: begin
              if (req.data.last_line >= req.data.first_line) begin
                ctx_line_d = adjust_line(ctx_line_q, req.data.first_line,
                    req.data.last_line, req.data.shift_amount, req.data.delete_range);
                pctx_line_d = adjust_line(pctx_line_q, req.data.first_line,
                    req.data.last_line, req.data.shift_amount, req.data.delete_range);
              end else begin
                idx_d = len_q; // nothing to walk
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        // Issue the read of idx; data arrives in S_WR.
        raddr = idx_q[IdxW-1:0];
        if (idx_q >= len_q && drop_start) begin
          // Shift entries 1..63 down by one; all of them are kept.
          drop_d = 1'b1;
          idx_d = CntW'(1);
          kept_d = '0;
        end
      end
      S_WR: begin
        idx_d = idx_q + 1'b1;
        raddr = idx_d[IdxW-1:0];
        if (r_q.cmd == CMD_ADJUST) begin
          if (rdata.file == r_q.file_num) begin
            we = 1'b1; waddr = idx_q[IdxW-1:0];
            wdata.line = adjust_line(rdata.line, r_q.first_line, r_q.last_line,
                r_q.shift_amount, r_q.delete_range);
          end
        end else if (rdata.line != r_q.cursor_line || rdata.file != r_q.file_num) begin
          // Compact kept entries toward the bottom.
          we = 1'b1; waddr = kept_q[IdxW-1:0];
          kept_d = kept_q + 1'b1;
        end
      end
      S_APPEND: begin
        if (r_q.cmd != CMD_ADJUST) begin
          we = 1'b1;
          wdata.line = r_q.cursor_line; wdata.col = r_q.cursor_col;
          wdata.file = r_q.file_num;
          waddr = kept_q[IdxW-1:0];
          len_d = kept_q + 1'b1;
          pos_d = kept_q + 1'b1;
          if (mv_q) begin
            // Cursor on the last entry, then step from there.
            pos_d = kept_q;
            if (app_bad) begin
              st_d = ST_NONE;
            end else begin
              pos_d = CntW'(app_idx);
              raddr = pos_d[IdxW-1:0];
            end
          end
        end
      end
      S_TGT: begin
        if (!mv_q) begin
          if (mv_bad) begin
            st_d = ST_NONE;
          end else if (pos_q >= len_q) begin
            // First move after a jump: record the cursor position first.
            mv_d = 1'b1;
            pctx_line_d = ctx_line_q; pctx_col_d = ctx_col_q;
            ctx_line_d = r_q.cursor_line; ctx_col_d = r_q.cursor_col;
            idx_d = '0; kept_d = '0;
          end else begin
            pos_d = CntW'(step_idx);
            raddr = pos_d[IdxW-1:0];
            mv_d = 1'b1;
            st_d = ST_OK;
          end
        end else begin
          tgt_d = rdata;
          st_d = (rdata.file != r_q.file_num) ? ST_OTHER : ST_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q <= '0; pos_q <= '0; idx_q <= '0; kept_q <= '0;
      ctx_line_q <= '0; ctx_col_q <= '0; pctx_line_q <= '0; pctx_col_q <= '0;
      mv_q <= 1'b0; drop_q <= 1'b0; st_q <= ST_OK;
    end else begin
      state_q <= state_d;
      len_q <= len_d; pos_q <= pos_d; idx_q <= idx_d; kept_q <= kept_d;
      ctx_line_q <= ctx_line_d; ctx_col_q <= ctx_col_d;
      pctx_line_q <= pctx_line_d; pctx_col_q <= pctx_col_d;
      mv_q <= mv_d; drop_q <= drop_d; st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q <= tgt_d;
    if (accept) r_q <= req.data;
  end

  assign rsp.valid = (state_q == S_OUT);
  assign rsp.data.status = st_q;
  assign rsp.data.target_line = tgt_q.line;
  assign rsp.data.target_col = tgt_q.col;
  assign rsp.data.target_file = tgt_q.file;
  assign rsp.data.context_line = ctx_line_q;
  assign rsp.data.context_col = ctx_col_q;
  assign rsp.data.list_length = 7'(len_q);
  assign rsp.data.list_position = 7'(pos_q);
endmodule

// File: src/jhl_checker.sv
// Port-level checker for the jump history list core, bound to the top level.
// Depends on jhl_pkg.
module jhl_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input logic [6:0] len_i,
  input logic [6:0] pos_i
);
  import jhl_pkg::*;
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_ready_i && rsp_valid_i)) else $error("accept while result pending");
  a_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> pos_i <= len_i) else $error("cursor past length");
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> len_i <= 7'(ListDepth)) else $error("length overflow");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i) else $error("result dropped");
endmodule

bind jump_history_list_core jhl_checker u_chk (
  .clk_i, .rst_ni,
  .req_valid_i(req.valid), .req_ready_i(req.ready),
  .rsp_valid_i(rsp.valid), .rsp_ready_i(rsp.ready),
  .len_i(rsp.data.list_length), .pos_i(rsp.data.list_position)
);

// File: sim/tb_jump_history_list_core.sv
// Testbench for jump_history_list_core: random and directed navigation commands
// checked against an in-bench model of the jump list. Depends on jhl_pkg, jhl_if.
`timescale 1ns / 1ps
module tb_jump_history_list_core;
  import jhl_pkg::*;

  localparam int unsigned Depth = ListDepth;
  localparam longint CycleLimit = 2_000_000;
  localparam int unsigned HoldCycles = 600;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  jhl_req_if req ();
  jhl_rsp_if rsp ();

  jump_history_list_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req.sink),
    .rsp    (rsp.source)
  );

  // Model state of the jump list.
  entry_t           hist_q [Depth];
  int unsigned      hist_len;
  int unsigned      hist_pos;
  logic [LineW-1:0] mark_line, prev_mark_line;
  logic [ColW-1:0]  mark_col, prev_mark_col;

  req_t cmd_queue [$];
  rsp_t rsp_expected [$];
  int   errors = 0;
  int   n_checked = 0;
  int   n_move_hits = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   hold_off = 1'b0;
  bit   hold_req = 1'b0;
  int unsigned hold_cnt = 0;
  longint cycle_count = 0;

  // Shift or zero one line inside lo..hi, clamped to the line range.
  function automatic logic [LineW-1:0] shift_line(logic [LineW-1:0] line,
      logic [LineW-1:0] lo, logic [LineW-1:0] hi, logic signed [31:0] sh, bit del);
    longint v;
    if (line < lo || line > hi) return line;
    if (del) return '0;
    v = longint'(line) + longint'(sh);
    if (v < 0) v = 0;
    if (v > 64'h7FFF_FFFF) v = 64'h7FFF_FFFF;
    return v[LineW-1:0];
  endfunction

  // Save the cursor as a jump: drop duplicates, append, trim the oldest.
  task automatic record_jump(logic [LineW-1:0] line, logic [ColW-1:0] col,
                             logic [FileW-1:0] file);
    int unsigned kept;
    kept = 0;
    prev_mark_line = mark_line;
    prev_mark_col = mark_col;
    mark_line = line;
    mark_col = col;
    for (int i = 0; i < hist_len; i++)
      if (hist_q[i].line != line || hist_q[i].file != file) begin
        hist_q[kept] = hist_q[i];
        kept++;
      end
    if (kept >= Depth) begin
      for (int i = 1; i < Depth; i++) hist_q[i-1] = hist_q[i];
      kept = Depth - 1;
    end
    hist_q[kept] = '{line: line, col: col, file: file};
    hist_len = kept + 1;
    hist_pos = hist_len;
  endtask

  task automatic predict_jump(input req_t r, output rsp_t o);
    int idx;
    o = '0;
    o.status = ST_OK;
    case (cmd_e'(r.cmd))
      CMD_RECORD: record_jump(r.cursor_line, r.cursor_col, r.file_num);
      CMD_MOVE: begin
        idx = int'(hist_pos) + int'(r.step_count);
        if (hist_len == 0 || idx < 0 || idx >= int'(hist_len)) begin
          o.status = ST_NONE;
        end else begin
          // First move after a jump records the cursor first.
          if (hist_pos >= hist_len) begin
            record_jump(r.cursor_line, r.cursor_col, r.file_num);
            hist_pos = hist_len - 1;
            idx = int'(hist_pos) + int'(r.step_count);
          end
          if (idx < 0 || idx >= int'(hist_len)) begin
            o.status = ST_NONE;
          end else begin
            hist_pos = idx;
            o.target_line = hist_q[idx].line;
            o.target_col = hist_q[idx].col;
            o.target_file = hist_q[idx].file;
            o.status = (hist_q[idx].file != r.file_num) ? ST_OTHER : ST_OK;
            n_move_hits++;
          end
        end
      end
      CMD_CHECK: begin
        if (prev_mark_line != 0 && (mark_line == r.cursor_line || mark_line == 0)) begin
          mark_line = prev_mark_line;
          mark_col = prev_mark_col;
          prev_mark_line = '0;
        end
      end
      default: begin
        if (r.last_line >= r.first_line) begin
          mark_line = shift_line(mark_line, r.first_line, r.last_line,
                                 r.shift_amount, r.delete_range);
          prev_mark_line = shift_line(prev_mark_line, r.first_line, r.last_line,
                                      r.shift_amount, r.delete_range);
          for (int i = 0; i < hist_len; i++)
            if (hist_q[i].file == r.file_num)
              hist_q[i].line = shift_line(hist_q[i].line, r.first_line,
                                          r.last_line, r.shift_amount, r.delete_range);
        end
      end
    endcase
    o.context_line = mark_line;
    o.context_col = mark_col;
    o.list_length = 7'(hist_len);
    o.list_position = 7'(hist_pos);
  endtask

  // Driver: offer the next pending command, advance on each transaction.
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t o;
    if (!rst_ni) begin
      req.valid <= 1'b0;
      req.data <= '0;
    end else begin
      if (req.valid && req.ready) begin
        predict_jump(req.data, o);
        rsp_expected.push_back(o);
        void'(cmd_queue.pop_front());
      end
      if (!req.valid || req.ready) begin
        if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req.valid <= 1'b1;
          req.data <= cmd_queue[0];
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver hold-off: once requested, hold ready low until the hold counter runs out.
  always @(posedge clk_i) begin
    if (hold_off) begin
      if (hold_cnt == HoldCycles - 1) hold_off <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else if (hold_req) begin
      hold_off <= 1'b1;
      hold_cnt <= 0;
    end
  end

  // Monitor: stall at random, compare each response with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t e;
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (rsp_expected.size() == 0) begin
          errors++;
          $display("%0t: unexpected response %h", $time, rsp.data);
        end else begin
          e = rsp_expected.pop_front();
          n_checked++;
          if (rsp.data.status != e.status)
            $display("%0t: status exp %0d got %0d", $time, e.status, rsp.data.status);
          if (rsp.data.target_line != e.target_line)
            $display("%0t: target_line exp %0d got %0d", $time, e.target_line,
                     rsp.data.target_line);
          if (rsp.data.target_col != e.target_col)
            $display("%0t: target_col exp %0d got %0d", $time, e.target_col,
                     rsp.data.target_col);
          if (rsp.data.target_file != e.target_file)
            $display("%0t: target_file exp %0d got %0d", $time, e.target_file,
                     rsp.data.target_file);
          if (rsp.data.context_line != e.context_line)
            $display("%0t: context_line exp %0d got %0d", $time, e.context_line,
                     rsp.data.context_line);
          if (rsp.data.context_col != e.context_col)
            $display("%0t: context_col exp %0d got %0d", $time, e.context_col,
                     rsp.data.context_col);
          if (rsp.data.list_length != e.list_length)
            $display("%0t: list_length exp %0d got %0d", $time, e.list_length,
                     rsp.data.list_length);
          if (rsp.data.list_position != e.list_position)
            $display("%0t: list_position exp %0d got %0d", $time, e.list_position,
                     rsp.data.list_position);
          if (rsp.data != e) errors++;
        end
      end
      rsp.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Small line and file pools make duplicates and adjust hits common.
  function automatic logic [LineW-1:0] pick_line();
    case ($urandom_range(9))
      0: return '0;
      1: return {LineW{1'b1}} - 31'($urandom_range(3));
      2: return 31'($urandom);
      default: return 31'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic req_t rand_cmd(int rec_bias);
    req_t r;
    int c;
    r.cursor_line = pick_line();
    r.cursor_col = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(5));
    r.file_num = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(3));
    r.step_count = ($urandom_range(7) == 0) ? 8'($urandom) :
                   8'(int'($urandom_range(8)) - 4);
    r.first_line = pick_line();
    r.last_line = ($urandom_range(4) == 0) ? pick_line() :
                  r.first_line + 31'($urandom_range(20));
    r.shift_amount = ($urandom_range(4) == 0) ? 32'($urandom) :
                     32'(int'($urandom_range(10)) - 5);
    r.delete_range = $urandom_range(1);
    c = $urandom_range(99);
    if (c < rec_bias) r.cmd = CMD_RECORD;
    else if (c < rec_bias + (100 - rec_bias) / 2) r.cmd = CMD_MOVE;
    else if ($urandom_range(1)) r.cmd = CMD_CHECK;
    else r.cmd = CMD_ADJUST;
    return r;
  endfunction

  task automatic wait_drained();
    while (cmd_queue.size() != 0 || req.valid || rsp_expected.size() != 0)
      @(posedge clk_i);
  endtask

  function automatic req_t mk(cmd_e c, logic [LineW-1:0] ln, logic [ColW-1:0] col,
                              logic [FileW-1:0] f, logic signed [7:0] st);
    req_t r;
    r = '0;
    r.cmd = c; r.cursor_line = ln; r.cursor_col = col; r.file_num = f; r.step_count = st;
    return r;
  endfunction

  initial begin
    req_t r;
    hist_len = 0; hist_pos = 0;
    mark_line = '0; mark_col = '0; prev_mark_line = '0; prev_mark_col = '0;
    req.valid = 1'b0;
    req.data = '0;
    rsp.ready = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty-list move, records, first move after jump, range, check, adjust.
    cmd_queue.push_back(mk(CMD_MOVE, 5, 1, 0, -1));
    cmd_queue.push_back(mk(CMD_CHECK, 0, 0, 0, 0));
    cmd_queue.push_back(mk(CMD_RECORD, 10, 3, 1, 0));
    cmd_queue.push_back(mk(CMD_RECORD, {LineW{1'b1}}, 16'hFFFF, 16'hFFFF, 0));
    cmd_queue.push_back(mk(CMD_RECORD, 20, 0, 1, 0));
    cmd_queue.push_back(mk(CMD_MOVE, 10, 7, 1, -1));   // duplicate removed by record
    cmd_queue.push_back(mk(CMD_MOVE, 0, 0, 1, 8'sh7F)); // out of range
    cmd_queue.push_back(mk(CMD_MOVE, 0, 0, 1, 8'sh80));
    cmd_queue.push_back(mk(CMD_MOVE, 0, 0, 2, -1));
    cmd_queue.push_back(mk(CMD_MOVE, 0, 0, 1, 1));
    cmd_queue.push_back(mk(CMD_CHECK, 10, 0, 1, 0));
    r = mk(CMD_ADJUST, 0, 0, 1, 0);
    r.first_line = 5; r.last_line = 4; r.shift_amount = 100;
    cmd_queue.push_back(r);                              // empty range
    r.first_line = 0; r.last_line = {LineW{1'b1}}; r.shift_amount = 32'sh7FFFFFFF;
    cmd_queue.push_back(r);                              // saturate high
    r.shift_amount = 32'sh80000000;
    cmd_queue.push_back(r);                              // saturate low
    r.delete_range = 1'b1; r.file_num = 16'hFFFF;
    cmd_queue.push_back(r);
    cmd_queue.push_back(mk(CMD_CHECK, 0, 0, 0, 0));
    for (int i = 0; i < 66; i++)                         // overflow drops oldest
      cmd_queue.push_back(mk(CMD_RECORD, 31'(100 + i), 16'(i), 3, 0));
    cmd_queue.push_back(mk(CMD_MOVE, 100, 0, 3, -64));
    wait_drained();

    // Random phases with different idle patterns.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? 66 : 0;
      recv_stall_pct = (ph == 2) ? 66 : (ph == 3) ? 17 : 0;
      if (ph == 3) send_idle_pct = 17;
      for (int i = 0; i < 330; i++) cmd_queue.push_back(rand_cmd(ph == 0 ? 60 : 40));
      wait_drained();
    end

    // Long receiver hold-off while commands keep coming.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 100; i++) cmd_queue.push_back(rand_cmd(40));
    hold_req = 1'b1;
    wait (hold_off);
    hold_req = 1'b0;
    wait (!hold_off);
    wait_drained();

    repeat (200) @(posedge clk_i);
    $display("tb: %0d responses checked, %0d moves landed on an entry", n_checked,
             n_move_hits);
    $display("tb: covered records, moves, checks, adjusts under idle and stall mixes");
    if (errors == 0 && rsp_expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// File: filelist.f
src/jhl_pkg.sv
src/jhl_if.sv
src/jhl_ram.sv
src/jump_history_list_core.sv
src/jhl_checker.sv
sim/tb_jump_history_list_core.sv
